// File: rtl/core/ibtl_pkg.sv
// ---------------------------------------------------------------------------
// ibtl_pkg
// Types and constants shared by the indirect branch target learner.
// ---------------------------------------------------------------------------
package ibtl_pkg;

   localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;
   localparam int unsigned HASH_SHIFT = 33;
   localparam logic [6:0] PCT_SCALE = 7'd100;

   localparam logic [1:0] PH_OBSERVE  = 2'd0;
   localparam logic [1:0] PH_LINKED   = 2'd1;
   localparam logic [1:0] PH_DISABLED = 2'd2;

   localparam logic CSR_LEARN_SAMPLES = 1'b0;
   localparam logic CSR_MIN_COVERAGE  = 1'b1;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] site_pc;
      logic [63:0] branch_target;
   } req_type;

   typedef struct packed {
      logic [1:0]  plan;
      logic        retranslate;
      logic        untracked;
      logic [1:0]  link_count;
      logic [63:0] target_0;
      logic [63:0] target_1;
      logic [63:0] target_2;
   } rsp_type;

endpackage

// File: rtl/core/indirect_branch_target_learner_core.sv
// ---------------------------------------------------------------------------
// indirect_branch_target_learner_core
// Per-site profiler for indirect branches with frozen target plans.
// ---------------------------------------------------------------------------
// One item at a time. An item passes through the hash and the entry memory
// read (all ways of a bucket in one row), then an evaluate step before its
// result is registered; when the plan freezes, selection sort passes (one
// per candidate slot) and a coverage step come in between. An item whose
// site has no entry and gets none skips the evaluate step. A result still
// held by the receiver keeps the next one waiting. The entry valid bits
// live in a bucket-wide valid memory that is cleared by a pass over all
// BUCKETS rows after reset, one row a cycle; no item is taken during that
// pass.
module indirect_branch_target_learner_core #(
   parameter int BUCKETS    = 4096,
   parameter int WAYS       = 2,
   parameter int CANDIDATES = 4,
   parameter int ACTIVE     = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ibtl_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ibtl_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);
   import ibtl_pkg::*;

   localparam int BB = $clog2(BUCKETS);
   localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CB = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
   localparam int NB = $clog2(CANDIDATES + 1);

   typedef struct packed {
      logic [63:0] tag;
      logic [1:0]  phase;
      logic [7:0]  total;
      logic [NB-1:0] used;
      logic [1:0]  ltotal;
      logic [CANDIDATES-1:0][63:0] saddr;
      logic [CANDIDATES-1:0][7:0]  shits;
      logic [2:0][63:0] laddr;
   } entry_type;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_HASH  = 8'b0000_0100,
      S_READ  = 8'b0000_1000,
      S_EVAL  = 8'b0001_0000,
      S_SORT  = 8'b0010_0000,
      S_COVER = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   entry_type mem_entry [BUCKETS][WAYS];
   logic [WAYS-1:0] mem_valid [BUCKETS];

   state_type   state_ff, state_in;
   logic [BB-1:0] clr_ff;
   logic [7:0]  learn_ff;
   logic [6:0]  cov_ff;
   req_type     req_ff;
   logic [1:0]  hcnt_ff;
   logic [BB-1:0] bucket;
   logic [BB-1:0] bkt_ff;
   entry_type   rd_ff [WAYS];
   logic [WAYS-1:0] vrow_ff;
   entry_type   ent_ff, ent_in;
   logic [WB-1:0] way_ff, way_in;
   logic        retr_ff, retr_in;
   logic [CB-1:0] si_ff;
   logic        wr_ff, wr_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff;
   logic        untr_ff;

   ibtl_hash #(.BUCKET_BITS(BB)) u_hash (
      .clock(clock), .start(state_ff == S_IDLE || state_ff == S_HASH),
      .site_pc(req_ff.site_pc), .bucket(bucket));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_ff <= 8'd32;
         cov_ff   <= 7'd90;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LEARN_SAMPLES: learn_ff <= csr_wdata;
            CSR_MIN_COVERAGE:  cov_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // bucket read: all ways of one row
   always_ff @(posedge clock) begin
      if (state_ff == S_HASH && hcnt_ff == 2'd1) begin
         bkt_ff <= bucket;
         vrow_ff <= mem_valid[bucket];
         for (int w = 0; w < WAYS; w++)
            rd_ff[w] <= mem_entry[bucket][w];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR)
         mem_valid[clr_ff] <= '0;
      else if (wr_ff) begin
         mem_valid[bkt_ff][way_ff] <= 1'b1;
         mem_entry[bkt_ff][way_ff] <= ent_ff;
      end
   end

   // eval
   logic        found;
   logic [WB-1:0] fway;
   logic        freefound;
   logic [WB-1:0] free_w;
   always_comb begin
      found = 1'b0; fway = '0; freefound = 1'b0; free_w = '0;
      for (int w = WAYS-1; w >= 0; w--) begin
         if (vrow_ff[w] && rd_ff[w].tag == req_ff.site_pc) begin
            found = 1'b1; fway = WB'(w);
         end
         if (!vrow_ff[w]) begin
            freefound = 1'b1; free_w = WB'(w);
         end
      end
   end

   logic [7:0] lim;
   assign lim = (learn_ff == 8'd0) ? 8'd1 : learn_ff;

   // sort pass: find best among slots si..n-1 and swap into si
   logic [CB-1:0] best;
   always_comb begin
      best = si_ff;
      for (int j = 0; j < CANDIDATES; j++)
         if (CB'(j) > si_ff && NB'(j) < ent_ff.used &&
             ent_ff.shits[j] > ent_ff.shits[best])
            best = CB'(j);
   end

   logic [9:0]  covered;
   logic [1:0]  act;
   logic [16:0] lhs, rhs;
   always_comb begin
      act = (int'(ent_ff.used) < ACTIVE) ? 2'(ent_ff.used) : 2'(ACTIVE);
      covered = '0;
      for (int i = 0; i < ACTIVE && i < CANDIDATES; i++)
         if (2'(i) < act) covered = covered + 10'(ent_ff.shits[i]);
      lhs = 17'(covered) * 17'(PCT_SCALE);
      rhs = 17'(ent_ff.total) * 17'(cov_ff);
   end

   logic        hit;
   logic [CB-1:0] hidx;
   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      way_in   = way_ff;
      retr_in  = retr_ff;
      wr_in    = 1'b0;
      rsp_in   = rsp_ff;
      hit = 1'b0; hidx = '0;
      for (int k = CANDIDATES-1; k >= 0; k--)
         if (NB'(k) < ent_ff.used && ent_ff.saddr[k] == req_ff.branch_target) begin
            hit = 1'b1; hidx = CB'(k);
         end
      case (state_ff)
         S_CLEAR: if (clr_ff == BB'(BUCKETS-1)) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_HASH;
         S_HASH:  if (hcnt_ff == 2'd1) state_in = S_READ;
         S_READ: begin
            retr_in = 1'b0;
            if (found) begin
               way_in = fway; ent_in = rd_ff[fway]; state_in = S_EVAL;
            end else if (req_ff.kind == KIND_LOOKUP || !freefound) begin
               state_in = S_OUT;
            end else begin
               way_in = free_w;
               ent_in = ent_ff;
               ent_in.tag = req_ff.site_pc;
               ent_in.phase = PH_OBSERVE;
               ent_in.total = '0; ent_in.used = '0; ent_in.ltotal = '0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_OUT;
            if (req_ff.kind == KIND_RECORD) begin
               wr_in = 1'b1;
               if (ent_ff.phase != PH_OBSERVE) retr_in = 1'b1;
               else if (!hit && ent_ff.used >= NB'(CANDIDATES)) begin
                  ent_in.phase = PH_DISABLED; retr_in = 1'b1;
               end else begin
                  if (hit) ent_in.shits[hidx] = ent_ff.shits[hidx] + 8'd1;
                  else begin
                     ent_in.saddr[ent_ff.used[CB-1:0]] = req_ff.branch_target;
                     ent_in.shits[ent_ff.used[CB-1:0]] = 8'd1;
                     ent_in.used = ent_ff.used + NB'(1);
                  end
                  ent_in.total = ent_ff.total + 8'd1;
                  if (ent_in.total >= lim) begin
                     retr_in = 1'b1; wr_in = 1'b0; state_in = S_SORT;
                  end
               end
            end
         end
         S_SORT: begin
            if (best != si_ff) begin
               ent_in.saddr[si_ff] = ent_ff.saddr[best];
               ent_in.shits[si_ff] = ent_ff.shits[best];
               ent_in.saddr[best]  = ent_ff.saddr[si_ff];
               ent_in.shits[best]  = ent_ff.shits[si_ff];
            end
            if (si_ff == CB'(CANDIDATES-1) || CANDIDATES == 1) state_in = S_COVER;
         end
         S_COVER: begin
            wr_in = 1'b1;
            state_in = S_OUT;
            if (act == 2'd0 || lhs < rhs) ent_in.phase = PH_DISABLED;
            else begin
               for (int i = 0; i < 3; i++)
                  if (i < ACTIVE && i < CANDIDATES && 2'(i) < act)
                     ent_in.laddr[i] = ent_ff.saddr[i];
               ent_in.ltotal = act;
               ent_in.phase = PH_LINKED;
            end
         end
         S_OUT: begin
            rsp_in = '0;
            if (untr_ff) rsp_in.untracked = !freefound;
            else begin
               rsp_in.plan = (ent_ff.phase == PH_OBSERVE || ent_ff.phase == PH_LINKED)
                             ? ent_ff.phase : PH_DISABLED;
               rsp_in.retranslate = retr_ff;
               if (ent_ff.phase == PH_LINKED) begin
                  rsp_in.link_count = (ent_ff.ltotal > 2'(ACTIVE)) ? 2'(ACTIVE)
                                                                  : ent_ff.ltotal;
                  if (rsp_in.link_count > 2'd0) rsp_in.target_0 = ent_ff.laddr[0];
                  if (rsp_in.link_count > 2'd1) rsp_in.target_1 = ent_ff.laddr[1];
                  if (rsp_in.link_count > 2'd2) rsp_in.target_2 = ent_ff.laddr[2];
               end
            end
            if (!rspv_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rspv_ff  <= 1'b0;
         wr_ff    <= 1'b0;
         hcnt_ff  <= '0;
         si_ff    <= '0;
         untr_ff  <= 1'b0;
      end else begin
         wr_ff <= wr_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + BB'(1);
         if (state_ff == S_HASH) hcnt_ff <= hcnt_ff + 2'd1;
         else hcnt_ff <= '0;
         if (state_ff == S_SORT) si_ff <= si_ff + CB'(1);
         else si_ff <= '0;
         if (state_ff == S_READ)
            untr_ff <= !found && (req_ff.kind == KIND_LOOKUP || !freefound);
         // hold the result until transfer
         if (state_ff == S_OUT && (!rspv_ff || !rsp_stall)) rspv_ff <= 1'b1;
         else if (rspv_ff && !rsp_stall) rspv_ff <= 1'b0;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      ent_ff  <= ent_in;
      way_ff  <= way_in;
      retr_ff <= retr_in;
      if (state_ff == S_OUT && (!rspv_ff || !rsp_stall))
         rsp_ff <= rsp_in;
   end

endmodule

// File: rtl/core/ibtl_hash.sv
// ---------------------------------------------------------------------------
// ibtl_hash
// Two-stage site hash: xor-shift, 64-bit multiply in three 32x32 partial
// products, then xor-shift and keep the low bits as bucket index.
// ---------------------------------------------------------------------------
module ibtl_hash #(
   parameter int BUCKET_BITS = 12
) (
   input  logic                   clock,
   input  logic                   start,
   input  logic [63:0]            site_pc,
   output logic [BUCKET_BITS-1:0] bucket
);
   import ibtl_pkg::*;

   logic [63:0] x0;
   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, hl_ff;
   logic [31:0] lh_in, hl_in;
   logic [63:0] prod;
   logic [63:0] x1;

   assign x0 = site_pc ^ (site_pc >> HASH_SHIFT);
   assign ll_in = {32'd0, x0[31:0]} * {32'd0, HASH_MULT[31:0]};
   // only the low half of the cross products reaches the result
   assign lh_in = x0[31:0] * HASH_MULT[63:32];
   assign hl_in = x0[63:32] * HASH_MULT[31:0];

   always_ff @(posedge clock) begin
      if (start) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
      end
   end

   assign prod = ll_ff + {lh_ff + hl_ff, 32'd0};
   assign x1 = prod ^ (prod >> HASH_SHIFT);
   assign bucket = x1[BUCKET_BITS-1:0];

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for indirect_branch_target_learner_core: drives lookup
// and record transfers through the request channel and predicts every plan
// with a bench-side model of the site table. It runs through several
// register settings, idle patterns and one long response hold-off.
// ---------------------------------------------------------------------------
module tb;
   import ibtl_pkg::*;

   localparam int NBUCKETS = 4096;
   localparam int NWAYS    = 2;
   localparam int NCAND    = 4;
   localparam int NACTIVE  = 3;
   localparam int NENTRIES = NBUCKETS * NWAYS;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic       csr_index = CSR_LEARN_SAMPLES;
   logic [7:0] csr_wdata = '0;

   indirect_branch_target_learner_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // bench copy of the site table
   bit          site_valid [NENTRIES];
   logic [63:0] site_tag   [NENTRIES];
   logic [1:0]  site_phase [NENTRIES];
   logic [7:0]  site_total [NENTRIES];
   logic [2:0]  site_used  [NENTRIES];
   logic [63:0] cand_addr  [NENTRIES*NCAND];
   logic [7:0]  cand_hits  [NENTRIES*NCAND];
   logic [63:0] link_addr  [NENTRIES*NACTIVE];
   logic [1:0]  link_total [NENTRIES];
   logic [7:0]  learn_limit = 8'd32;
   logic [6:0]  coverage_pct = 7'd90;

   req_type     req_backlog [$];
   rsp_type     plans_due [$];
   logic [63:0] known_sites [$];
   int          errors = 0;
   int          cycles = 0;
   int          idle_mode = 0;
   bit          req_sent = 1'b0;
   bit          press_go = 1'b0;
   bit          press_done = 1'b0;
   int          hold_left = 0;

   function automatic int site_bucket(logic [63:0] pc);
      logic [63:0] x;
      x = pc ^ (pc >> HASH_SHIFT);
      x = x * HASH_MULT;
      x = x ^ (x >> HASH_SHIFT);
      return int'(x[11:0]);
   endfunction

   function automatic void freeze_site(int e);
      logic [63:0] a [NCAND];
      logic [7:0]  h [NCAND];
      logic [63:0] ta;
      logic [7:0]  th;
      logic [63:0] covered;
      int n, best, act;
      n = site_used[e] > NCAND ? NCAND : site_used[e];
      for (int i = 0; i < n; i++) begin
         a[i] = cand_addr[e*NCAND+i];
         h[i] = cand_hits[e*NCAND+i];
      end
      for (int i = 0; i < n; i++) begin
         best = i;
         for (int j = i + 1; j < n; j++)
            if (h[j] > h[best]) best = j;
         if (best != i) begin
            ta = a[i]; th = h[i];
            a[i] = a[best]; h[i] = h[best];
            a[best] = ta; h[best] = th;
         end
      end
      act = n < NACTIVE ? n : NACTIVE;
      covered = '0;
      for (int i = 0; i < act; i++) covered += 64'(h[i]);
      if (act == 0 || covered * 64'd100 < 64'(site_total[e]) * 64'(coverage_pct)) begin
         site_phase[e] = PH_DISABLED;
         return;
      end
      for (int i = 0; i < act; i++) link_addr[e*NACTIVE+i] = a[i];
      link_total[e] = 2'(act);
      site_phase[e] = PH_LINKED;
   endfunction

   function automatic rsp_type plan_predict(req_type r);
      rsp_type o;
      int base, e, found, free_way, n;
      bit hit;
      o = '0;
      base = site_bucket(r.site_pc) * NWAYS;
      found = -1;
      free_way = -1;
      for (int w = 0; w < NWAYS; w++) begin
         if (site_valid[base+w]) begin
            if (found < 0 && site_tag[base+w] == r.site_pc) found = base + w;
         end else if (free_way < 0) free_way = base + w;
      end
      if (found < 0) begin
         if (r.kind == KIND_LOOKUP || free_way < 0) begin
            o.untracked = (free_way < 0);
            return o;
         end
         e = free_way;
         site_valid[e] = 1'b1;
         site_tag[e] = r.site_pc;
         site_phase[e] = PH_OBSERVE;
         site_total[e] = '0;
         site_used[e] = '0;
         link_total[e] = '0;
      end else e = found;
      if (r.kind == KIND_RECORD) begin
         if (site_phase[e] != PH_OBSERVE) o.retranslate = 1'b1;
         else begin
            hit = 1'b0;
            n = site_used[e] > NCAND ? NCAND : site_used[e];
            for (int k = 0; k < n; k++)
               if (!hit && cand_addr[e*NCAND+k] == r.branch_target) begin
                  cand_hits[e*NCAND+k]++;
                  hit = 1'b1;
               end
            if (!hit && n >= NCAND) begin
               site_phase[e] = PH_DISABLED;
               o.retranslate = 1'b1;
            end else begin
               if (!hit) begin
                  cand_addr[e*NCAND+n] = r.branch_target;
                  cand_hits[e*NCAND+n] = 8'd1;
                  site_used[e] = 3'(n + 1);
               end
               site_total[e]++;
               if (site_total[e] >= (learn_limit == 0 ? 8'd1 : learn_limit)) begin
                  freeze_site(e);
                  o.retranslate = 1'b1;
               end
            end
         end
      end
      o.plan = site_phase[e] > PH_DISABLED ? PH_DISABLED : site_phase[e];
      if (o.plan == PH_LINKED) begin
         n = link_total[e] > NACTIVE ? NACTIVE : link_total[e];
         o.link_count = 2'(n);
         if (n > 0) o.target_0 = link_addr[e*NACTIVE];
         if (n > 1) o.target_1 = link_addr[e*NACTIVE+1];
         if (n > 2) o.target_2 = link_addr[e*NACTIVE+2];
      end
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
      errors++;
   endtask

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("indirect_branch_target_learner_core regression: fail");
         $finish;
      end
   end

   // request side: predict on transfer
   always @(posedge clock) begin
      req_sent <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) plans_due.push_back(plan_predict(req_data));
   end

   // response side: check against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plans_due.size() == 0)
            report("unexpected response", 64'(rsp_data.plan), 64'd0);
         else begin
            want = plans_due.pop_front();
            if (rsp_data.plan != want.plan)
               report("plan", 64'(rsp_data.plan), 64'(want.plan));
            if (rsp_data.retranslate != want.retranslate)
               report("retranslate", 64'(rsp_data.retranslate), 64'(want.retranslate));
            if (rsp_data.untracked != want.untracked)
               report("untracked", 64'(rsp_data.untracked), 64'(want.untracked));
            if (rsp_data.link_count != want.link_count)
               report("link_count", 64'(rsp_data.link_count), 64'(want.link_count));
            if (rsp_data.target_0 != want.target_0)
               report("target_0", rsp_data.target_0, want.target_0);
            if (rsp_data.target_1 != want.target_1)
               report("target_1", rsp_data.target_1, want.target_1);
            if (rsp_data.target_2 != want.target_2)
               report("target_2", rsp_data.target_2, want.target_2);
         end
      end
   end

   // driver: hold a stalled item, advance after a transfer
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_sent)) begin
         if (req_backlog.size() > 0 &&
             !(idle_mode == 0 && $urandom_range(99) < 15) &&
             !(idle_mode == 1 && $urandom_range(99) < 49)) begin
            req_valid <= 1'b1;
            req_data <= req_backlog.pop_front();
         end else req_valid <= 1'b0;
      end
   end

   // receiver stall, with one long hold-off
   always @(negedge clock) begin
      if (press_go && !press_done) begin
         press_done <= 1'b1;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_mode == 0) rsp_stall <= ($urandom_range(99) < 49);
      else if (idle_mode == 1) rsp_stall <= ($urandom_range(99) < 15);
      else rsp_stall <= 1'b0;
   end

   task automatic add_item(logic kind, logic [63:0] pc, logic [63:0] tgt);
      req_type r;
      r.kind = kind;
      r.site_pc = pc;
      r.branch_target = tgt;
      req_backlog.push_back(r);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] bucket_mate(logic [63:0] pc);
      logic [63:0] c;
      int b;
      b = site_bucket(pc);
      do c = rand64(); while (site_bucket(c) != b || c == pc);
      return c;
   endfunction

   task automatic csr_put(logic idx, logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_LEARN_SAMPLES) learn_limit = val;
      else coverage_pct = val[6:0];
   endtask

   task automatic drain();
      while (req_backlog.size() > 0 || req_valid || plans_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one site trained with a few targets, biased toward the first ones
   task automatic add_site_run();
      logic [63:0] pc;
      logic [63:0] tg [5];
      int k, len;
      if (known_sites.size() > 0 && $urandom_range(99) < 20)
         pc = known_sites[$urandom_range(known_sites.size() - 1)];
      else begin
         pc = rand64();
         known_sites.push_back(pc);
      end
      k = $urandom_range(1, $urandom_range(99) < 85 ? 3 : 5);
      for (int i = 0; i < 5; i++) tg[i] = rand64();
      len = (learn_limit == 0 ? 1 : learn_limit) + $urandom_range(2);
      if (len > 40) len = $urandom_range(3, 12);
      for (int i = 0; i < len; i++) begin
         add_item(KIND_RECORD, pc, tg[$urandom_range($urandom_range(k - 1))]);
         if ($urandom_range(99) < 20) add_item(KIND_LOOKUP, pc, rand64());
      end
      add_item(KIND_LOOKUP, pc, rand64());
   endtask

   task automatic add_random(int count);
      int goal;
      goal = req_backlog.size() + count;
      while (req_backlog.size() < goal) begin
         if ($urandom_range(99) < 75) add_site_run();
         else if (known_sites.size() > 0 && $urandom_range(1))
            add_item(1'($urandom_range(1)),
                     known_sites[$urandom_range(known_sites.size() - 1)], rand64());
         else add_item(1'($urandom_range(1)), rand64(), rand64());
      end
   endtask

   initial begin
      logic [63:0] sa, sb, sc, lo;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: extremes, unknown site, overflow, full bucket
      idle_mode = 0;
      add_item(KIND_LOOKUP, 64'h0, 64'h0);
      add_item(KIND_RECORD, 64'h0, 64'hffff_ffff_ffff_ffff);
      add_item(KIND_RECORD, 64'hffff_ffff_ffff_ffff, 64'h0);
      add_item(KIND_LOOKUP, 64'hffff_ffff_ffff_ffff, 64'h0);
      sa = rand64();
      for (int i = 0; i < 5; i++) add_item(KIND_RECORD, sa, rand64());
      add_item(KIND_RECORD, sa, rand64());
      add_item(KIND_LOOKUP, sa, 64'h0);
      sb = bucket_mate(sa);
      sc = bucket_mate(sa);
      add_item(KIND_RECORD, sb, 64'h1234);
      add_item(KIND_RECORD, sc, 64'h5678);
      add_item(KIND_LOOKUP, sc, 64'h0);
      known_sites.push_back(sa);
      known_sites.push_back(sb);
      known_sites.push_back(sc);
      add_random(120);
      drain();

      // learn_samples zero acts as one; no coverage needed
      csr_put(CSR_LEARN_SAMPLES, 8'd0);
      csr_put(CSR_MIN_COVERAGE, 8'd0);
      sa = rand64();
      add_item(KIND_RECORD, sa, 64'hffff_ffff_ffff_ffff);
      add_item(KIND_RECORD, sa, 64'h0);
      add_item(KIND_LOOKUP, sa, 64'h0);
      add_random(100);
      drain();

      // longest training, full coverage; top bit of the data is dropped
      idle_mode = 1;
      csr_put(CSR_LEARN_SAMPLES, 8'd255);
      csr_put(CSR_MIN_COVERAGE, 8'he4);
      lo = rand64();
      for (int i = 0; i < 6; i++) add_item(KIND_RECORD, lo, 64'(i % 3));
      add_random(100);
      drain();

      // lowered limit freezes an older site; coverage above one hundred
      csr_put(CSR_LEARN_SAMPLES, 8'd3);
      csr_put(CSR_MIN_COVERAGE, 8'd127);
      add_item(KIND_RECORD, lo, 64'd1);
      add_item(KIND_LOOKUP, lo, 64'd0);
      add_random(120);
      drain();

      idle_mode = 2;
      csr_put(CSR_LEARN_SAMPLES, 8'd8);
      csr_put(CSR_MIN_COVERAGE, 8'd60);
      press_go = 1'b1;
      add_random(220);
      drain();

      csr_put(CSR_LEARN_SAMPLES, 8'd1);
      csr_put(CSR_MIN_COVERAGE, 8'd90);
      add_random(150);
      drain();

      if (errors == 0) $display("indirect_branch_target_learner_core regression: pass");
      else $display("indirect_branch_target_learner_core regression: fail");
      $finish;
   end

endmodule

// File: indirect_branch_target_learner_core.f
rtl/core/ibtl_pkg.sv
rtl/core/ibtl_hash.sv
rtl/core/indirect_branch_target_learner_core.sv
tb/tb.sv
